// ===== design/pft_pkg.sv =====
`default_nettype none
package pft_pkg;
  localparam int FRONT_DEPTH = 64;
  localparam int AW = $clog2(FRONT_DEPTH);
  localparam int CW = $clog2(FRONT_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        we;
    logic [AW-1:0] waddr;
    logic [63:0] wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

// ===== design/pft_ram.sv =====
`default_nettype none
module pft_ram
  import pft_pkg::*;
(
  input  wire logic        clk,
  input  wire mem_req_t    req,
  output logic [63:0]      rdata
);
  logic [63:0] mem [FRONT_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

// ===== design/pareto_frontier_table_core.sv =====
`default_nettype none
// Pareto frontier table: keeps non-dominated (time, fuel) points, both
// minimized, sorted by rising time in one 64-bit wide synchronous RAM.
// Input request on in_*: tdata holds point_time, point_fuel, read_index and
// from_tail from the low bit up; tuser = cmd (0 insert, 1 read).
// One result per request on out_*.
// Insert: a scan pass reads every entry once and checks dominance both
// ways; if the point stays, a compaction pass rereads the table, drops
// dominated entries and writes the rest plus the new point in place,
// lower addresses first. A dropped or refused point skips compaction.
// Read: one RAM read, none when the index is out of range.
// One request at a time: in_tready is low while a request is at work or
// its result waits in the output register, so a new request is taken
// only once the last result has left. A stalled receiver holds the
// result and blocks new requests. Reset empties the table and clears
// the seen counter; RAM contents need no clearing as only live entries
// are read.
module pareto_frontier_table_core
  import pft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // point_time[31:0], point_fuel[63:32], read_index[69:64], from_tail[70]
  input  wire logic [71:0] in_tdata,
  // cmd
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // accepted[0], overflow[1], frontier_size[8:2], points_seen[40:9],
  // entry_valid[41], entry_time[73:42], entry_fuel[105:74]
  output logic [111:0]     out_tdata
);
  state_t st_r, st_nxt;
  logic [31:0] t_r, f_r, seen_r;
  logic [5:0]  idx_r;
  logic        tail_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW:0]   i_r, i_nxt;          // read pointer (issue)
  logic [CW-1:0] w_r, w_nxt;          // write pointer
  logic        vld_r, vld_nxt;        // rdata holds entry i_r-1 in scan and compaction
  logic        dom_r, dom_nxt, kill_r, kill_nxt, ins_r, ins_nxt;
  logic        acc_r, acc_nxt, ovf_r, ovf_nxt, ev_r, ev_nxt;
  logic [31:0] et_r, et_nxt, ef_r, ef_nxt;
  logic [63:0] held_r, held_nxt;      // displaced entry during compaction
  logic        hv_r, hv_nxt;
  mem_req_t    req;
  logic [63:0] rdata;
  logic [31:0] rt, rf;
  logic        rd_dom, rd_kill;

  pft_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  assign rt = rdata[31:0];
  assign rf = rdata[63:32];
  assign rd_dom  = (rt <= t_r) && (rf <= f_r);
  assign rd_kill = (t_r <= rt) && (f_r <= rf);
  assign in_tready = (st_r == ST_IDLE);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:    if (in_tvalid) st_nxt = in_tuser ? ST_READ : ST_SCAN;
      ST_SCAN:    if (!vld_r && !(i_r < {1'b0, cnt_r})) st_nxt = (dom_r || (!kill_r &&
                      cnt_r == CW'(FRONT_DEPTH))) ? ST_OUT : ST_COMPACT;
      ST_COMPACT: if (!vld_r && !hv_r && ins_r && i_r != '0) st_nxt = ST_OUT;
      ST_READ:    if (!vld_r && i_r != '0) st_nxt = ST_OUT;
      ST_OUT:     if (out_tready) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [CW:0] p;
    logic [63:0] nd;
    p = '0;
    nd = '0;
    req = '0;
    i_nxt = i_r; w_nxt = w_r; vld_nxt = 1'b0; cnt_nxt = cnt_r;
    dom_nxt = dom_r; kill_nxt = kill_r; ins_nxt = ins_r;
    acc_nxt = acc_r; ovf_nxt = ovf_r; ev_nxt = ev_r; et_nxt = et_r; ef_nxt = ef_r;
    held_nxt = held_r; hv_nxt = hv_r;
    unique case (st_r)
      ST_IDLE: begin
        i_nxt = '0; w_nxt = '0; dom_nxt = 1'b0; kill_nxt = 1'b0; ins_nxt = 1'b0;
        acc_nxt = 1'b0; ovf_nxt = 1'b0; ev_nxt = 1'b0; et_nxt = '0; ef_nxt = '0;
        hv_nxt = 1'b0;
      end
      ST_SCAN: begin
        if (vld_r) begin
          if (rd_dom) dom_nxt = 1'b1;
          if (rd_kill) kill_nxt = 1'b1;
        end
        if (i_r < {1'b0, cnt_r}) begin
          req.raddr = i_r[AW-1:0];
          vld_nxt = 1'b1;
          i_nxt = i_r + 1'b1;
        end else if (!vld_r) begin
          i_nxt = '0;
          if (dom_r) begin
          end else if (!kill_r && cnt_r == CW'(FRONT_DEPTH)) ovf_nxt = 1'b1;
        end
      end
      ST_COMPACT: begin
        // stream: survivors and new point written at w, held entry buffers
        // the one that would be overwritten before it was read (w <= i-1).
        if (vld_r) begin
          if (!rd_kill) begin
            nd = rdata;
            if (!ins_r && rt > t_r) begin
              req.we = 1'b1; req.waddr = w_r[AW-1:0]; req.wdata = {f_r, t_r};
              ins_nxt = 1'b1; held_nxt = rdata; hv_nxt = 1'b1;
              w_nxt = w_r + 1'b1;
            end else if (hv_r) begin
              req.we = 1'b1; req.waddr = w_r[AW-1:0]; req.wdata = held_r;
              held_nxt = nd; w_nxt = w_r + 1'b1;
            end else begin
              req.we = 1'b1; req.waddr = w_r[AW-1:0]; req.wdata = nd;
              w_nxt = w_r + 1'b1;
            end
          end
        end else if (!(i_r < {1'b0, cnt_r}) && i_r != '0) begin
          if (hv_r) begin
            req.we = 1'b1; req.waddr = w_r[AW-1:0]; req.wdata = held_r;
            hv_nxt = 1'b0; w_nxt = w_r + 1'b1;
          end else if (!ins_r) begin
            req.we = 1'b1; req.waddr = w_r[AW-1:0]; req.wdata = {f_r, t_r};
            ins_nxt = 1'b1; w_nxt = w_r + 1'b1;
          end else begin
            cnt_nxt = w_r; acc_nxt = 1'b1;
          end
        end
        if (i_r < {1'b0, cnt_r}) begin
          req.raddr = i_r[AW-1:0];
          vld_nxt = 1'b1;
          i_nxt = i_r + 1'b1;
        end else if (i_r == '0) begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_READ: begin
        if (vld_r) begin
          ev_nxt = 1'b1; et_nxt = rt; ef_nxt = rf;
        end
        if (i_r == '0) begin
          i_nxt = i_r + 1'b1;
          if ({1'b0, idx_r} < cnt_r) begin
            p = tail_r ? ((CW+1)'(cnt_r) - 1'b1 - (CW+1)'(idx_r)) : (CW+1)'(idx_r);
            req.raddr = p[AW-1:0];
            vld_nxt = 1'b1;
          end
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; seen_r <= '0; vld_r <= 1'b0;
      i_r <= '0; hv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; vld_r <= vld_nxt; i_r <= i_nxt;
      hv_r <= hv_nxt;
      if (in_tvalid && in_tready && !in_tuser && seen_r != '1) seen_r <= seen_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      t_r <= in_tdata[31:0]; f_r <= in_tdata[63:32];
      idx_r <= in_tdata[69:64]; tail_r <= in_tdata[70];
    end
    w_r <= w_nxt; dom_r <= dom_nxt; kill_r <= kill_nxt; ins_r <= ins_nxt;
    acc_r <= acc_nxt; ovf_r <= ovf_nxt; ev_r <= ev_nxt; et_r <= et_nxt;
    ef_r <= ef_nxt; held_r <= held_nxt;
  end

  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata = {6'b0, ef_r, et_r, ev_r, seen_r, 7'(cnt_r), ovf_r, acc_r};

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(FRONT_DEPTH)) else $error("count beyond depth");
  a_acc_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(acc_r && ovf_r)) else $error("accepted with overflow");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("request taken while result waits");
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_READ) |=> $stable(cnt_r)) else $error("read changed count");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_pareto_frontier_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_pareto_frontier_table_core;
  import pft_pkg::*;

  localparam int N_RANDOM = 900;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } frontier_op_e;

  typedef struct packed {
    logic [31:0] entry_fuel;
    logic [31:0] entry_time;
    logic        entry_valid;
    logic [31:0] points_seen;
    logic [6:0]  frontier_size;
    logic        overflow;
    logic        accepted;
  } frontier_result_t;

  // Frontier predictor plus FIFO of expected results.
  class frontier_scoreboard;
    logic [31:0] pt_time[FRONT_DEPTH];
    logic [31:0] pt_fuel[FRONT_DEPTH];
    int unsigned live_count;
    logic [31:0] seen_total;
    frontier_result_t pending_results[$];
    int unsigned mismatch_count;
    int unsigned checked_count;
    int unsigned accept_count;
    int unsigned overflow_count;
    int unsigned max_size;

    function new();
      live_count = 0;
      seen_total = '0;
      mismatch_count = 0;
      checked_count = 0;
      accept_count = 0;
      overflow_count = 0;
      max_size = 0;
    endfunction

    function void note_request(frontier_op_e op, logic [31:0] t, logic [31:0] f,
                               logic [5:0] idx, logic tail);
      frontier_result_t r;
      int unsigned kill;
      int unsigned w;
      int unsigned pos;
      bit dominated;
      r = '0;
      if (op == OP_INSERT) begin
        if (seen_total != 32'hFFFF_FFFF) seen_total = seen_total + 1;
        dominated = 0;
        kill = 0;
        for (int i = 0; i < live_count; i++) begin
          if (pt_time[i] <= t && pt_fuel[i] <= f) dominated = 1;
          if (t <= pt_time[i] && f <= pt_fuel[i]) kill++;
        end
        if (!dominated) begin
          if (kill == 0 && live_count >= FRONT_DEPTH) begin
            r.overflow = 1'b1;
            overflow_count++;
          end else begin
            w = 0;
            for (int i = 0; i < live_count; i++) begin
              if (!(t <= pt_time[i] && f <= pt_fuel[i])) begin
                pt_time[w] = pt_time[i];
                pt_fuel[w] = pt_fuel[i];
                w++;
              end
            end
            pos = 0;
            while (pos < w && pt_time[pos] < t) pos++;
            for (int i = w; i > pos; i--) begin
              pt_time[i] = pt_time[i - 1];
              pt_fuel[i] = pt_fuel[i - 1];
            end
            pt_time[pos] = t;
            pt_fuel[pos] = f;
            live_count = w + 1;
            r.accepted = 1'b1;
            accept_count++;
            if (live_count > max_size) max_size = live_count;
          end
        end
      end else if (idx < live_count) begin
        pos = tail ? (live_count - 1 - idx) : idx;
        r.entry_valid = 1'b1;
        r.entry_time = pt_time[pos];
        r.entry_fuel = pt_fuel[pos];
      end
      r.frontier_size = live_count[6:0];
      r.points_seen = seen_total;
      pending_results.push_back(r);
    endfunction

    function void check_result(frontier_result_t got);
      frontier_result_t exp;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending_results.pop_front();
      checked_count++;
      if (got !== exp) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"mismatch #%0d: acc %b/%b ovf %b/%b size %0d/%0d seen %0d/%0d",
                    " val %b/%b t %h/%h f %h/%h"},
                   checked_count, exp.accepted, got.accepted, exp.overflow, got.overflow,
                   exp.frontier_size, got.frontier_size, exp.points_seen, got.points_seen,
                   exp.entry_valid, got.entry_valid, exp.entry_time, got.entry_time,
                   exp.entry_fuel, got.entry_fuel);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [71:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;

  frontier_scoreboard sb;
  int unsigned cycle_count;
  bit          idle_enabled;
  bit          hold_off;

  pareto_frontier_table_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: fail hard if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(frontier_result_t'(out_tdata[105:0]));
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned n;
    out_tready = 1'b0;
    @(posedge clk);
    while (1) begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one request; hold it until the block takes it.
  task automatic send_request(frontier_op_e op, logic [31:0] t, logic [31:0] f,
                              logic [5:0] idx, logic tail);
    int unsigned gap;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, tail, idx, f, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, t, f, idx, tail);
  endtask

  task automatic send_insert(logic [31:0] t, logic [31:0] f);
    send_request(OP_INSERT, t, f, 6'($urandom), 1'($urandom));
  endtask

  task automatic send_read(logic [5:0] idx, logic tail);
    send_request(OP_READ, $urandom, $urandom, idx, tail);
  endtask

  // Points on a staircase: rising time, falling fuel, with random jitter.
  task automatic send_staircase(int unsigned n, logic [31:0] span);
    logic [31:0] step;
    step = span / (n + 1);
    for (int k = 0; k < n; k++)
      send_insert(step * (k + 1) + $urandom_range(0, step / 2),
                  32'hFFFF_0000 - step * (k + 1) + $urandom_range(0, step / 2));
  endtask

  initial begin
    int unsigned sel;
    sb = new();
    cycle_count = 0;
    idle_enabled = 1;
    hold_off = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty reads, full table, extremes, equal point, domination.
    send_read(6'd0, 1'b0);
    send_read(6'd63, 1'b1);
    send_staircase(70, 32'hFFFF_0000);
    for (int j = 0; j < 6; j++) send_read(6'($urandom_range(60, 63)), 1'($urandom));
    send_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_insert(32'h0000_0000, 32'hFFFF_FFFF);
    send_insert(32'hFFFF_FFFF, 32'h0000_0000);
    send_insert(32'h0001_0000, 32'h0002_0000);
    send_insert(32'h0002_0000, 32'h0001_0000);
    send_insert(32'h0001_0000, 32'h0001_0000);
    send_insert(32'h0001_8000, 32'h0003_0000);
    send_read(6'd0, 1'b0);
    send_read(6'd0, 1'b1);
    send_read(6'd2, 1'b0);
    send_read(6'd3, 1'b1);
    send_read(6'd4, 1'b0);
    send_insert(32'h5555_5555, 32'hAAAA_AAAA);
    send_insert(32'hAAAA_AAAA, 32'h5555_5555);

    // Long receiver hold-off while requests keep coming.
    hold_off = 1;
    send_staircase(12, 32'hFFFF_0000);

    // Random: every 300 steps a staircase that fills the table, else noise and reads.
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - 150) idle_enabled = 0;
      if (k % 300 == 0) begin
        send_staircase(70, 32'hFFFF_0000);
        for (int j = 0; j < 6; j++) send_read(6'($urandom_range(60, 63)), 1'($urandom));
      end
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2: send_read(6'($urandom), 1'($urandom));
        3:       send_insert($urandom, $urandom);
        4:       send_insert($urandom_range(0, 255), $urandom_range(0, 255));
        5:       send_insert(32'hFFFF_FFFF - $urandom_range(0, 3), $urandom);
        default: send_insert($urandom_range(0, 32'h00FF_FFFF) << 8,
                             32'hFFFF_FFFF - ($urandom_range(0, 32'h00FF_FFFF) << 8));
      endcase
    end

    // A point that dominates everything leaves one entry.
    send_insert(32'h0000_0000, 32'h0000_0000);
    send_read(6'd0, 1'b1);
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d results: %0d points placed, %0d refused as full,",
             sb.checked_count, sb.accept_count, sb.overflow_count);
    $display("largest frontier %0d, with stalls on both sides", sb.max_size);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.mismatch_count);
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
